/* rtl/sysex_message_framer_defines.svh */
// ----------------------------------------------------------------------------
// sysex message framer assertion macros
// shared concurrent assertion wrappers for the framer checker
// ----------------------------------------------------------------------------
`ifndef SYSEX_MESSAGE_FRAMER_DEFINES_SVH
`define SYSEX_MESSAGE_FRAMER_DEFINES_SVH

// property checked only outside reset
`define SMF_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define SMF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/smf_pkg.sv */
// ----------------------------------------------------------------------------
// smf_pkg
// constants, slot codes and item type of the sysex message framer
// ----------------------------------------------------------------------------
`default_nettype none

package smf_pkg;

  // framing bytes
  localparam logic [7:0] SYX_START  = 8'hF0;
  localparam logic [7:0] SYX_MAKER  = 8'h41;
  localparam logic [7:0] SYX_MODEL  = 8'h6A;
  localparam logic [7:0] SYX_CMD_RQ = 8'h11;
  localparam logic [7:0] SYX_CMD_DT = 8'h12;
  localparam logic [7:0] SYX_END    = 8'hF7;

  // device byte after reset
  localparam logic [6:0] DEVICE_RESET = 7'd16;

  // byte slots of one framed message in transmit order
  localparam logic [2:0] SLOT_START = 3'd0;
  localparam logic [2:0] SLOT_MAKER = 3'd1;
  localparam logic [2:0] SLOT_DEV   = 3'd2;
  localparam logic [2:0] SLOT_MODEL = 3'd3;
  localparam logic [2:0] SLOT_CMD   = 3'd4;
  localparam logic [2:0] SLOT_PAY   = 3'd5;
  localparam logic [2:0] SLOT_CKSUM = 3'd6;
  localparam logic [2:0] SLOT_END   = 3'd7;

  // one held input item with its checksum
  typedef struct packed {
    logic       req_type;
    logic [7:0] payload_byte;
    logic       first_byte;
    logic       last_byte;
    logic [6:0] cksum;
  } item_t;

endpackage

`default_nettype wire

/* rtl/sysex_message_framer.sv */
// ----------------------------------------------------------------------------
// sysex_message_framer
// frames body bytes into system-exclusive update and request messages
// ----------------------------------------------------------------------------
// One input transaction holds one body byte. A byte marked first is preceded
// by F0 41 <device> 6A <cmd> (11 request, 12 update); a byte marked last is
// followed by the checksum and F7. Each input transaction yields one to eight
// output transactions, one per cycle while the output is not stalled, so a
// body byte in mid-message yields one, and the input is taken every cycle
// while the output is not stalled. The single output register sends one byte
// per cycle when not stalled: a first byte yields six bytes, a last byte
// three, a one-byte message eight. Input and output are parted by the input
// item register and the output register, so the next byte is taken while a
// result waits. device_id is a plain write-only register, reset to 16.
// ----------------------------------------------------------------------------
`default_nettype none

module sysex_message_framer (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [6:0] cfg_wdata_i,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic       req_type_i,
  input  wire logic [7:0] payload_byte_i,
  input  wire logic       first_byte_i,
  input  wire logic       last_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic            run_end_o,
  output logic            message_end_o
);
  import smf_pkg::*;

  logic [6:0] device_id_q;
  logic       item_valid;
  item_t      item;
  logic       pop;

  // device byte register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      device_id_q <= DEVICE_RESET;
    end else if (cfg_we_i) begin
      device_id_q <= cfg_wdata_i;
    end
  end

  // input register and checksum
  smf_in_stage u_in_stage (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .payload_byte_i (payload_byte_i),
    .first_byte_i   (first_byte_i),
    .last_byte_i    (last_byte_i),
    .pop_i          (pop),
    .item_valid_o   (item_valid),
    .item_o         (item)
  );

  // byte sequencer and output register
  smf_emit u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (item_valid),
    .item_i        (item),
    .device_id_i   (device_id_q),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .run_end_o     (run_end_o),
    .message_end_o (message_end_o)
  );

endmodule

`default_nettype wire

/* rtl/smf_in_stage.sv */
// ----------------------------------------------------------------------------
// smf_in_stage
// input register with the seven-bit running sum and checksum
// ----------------------------------------------------------------------------
`default_nettype none

module smf_in_stage (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire logic          req_type_i,
  input  wire logic [7:0]    payload_byte_i,
  input  wire logic          first_byte_i,
  input  wire logic          last_byte_i,
  input  wire logic          pop_i,
  output logic               item_valid_o,
  output smf_pkg::item_t     item_o
);
  import smf_pkg::*;

  logic       item_valid_q, item_valid_d;
  item_t      item_q, item_d;
  logic [6:0] sum_q, sum_d;
  logic [6:0] sum_new;
  logic       accept;

  // the register frees up in the cycle its last byte leaves
  assign in_stall_o = item_valid_q && !pop_i;
  assign accept     = in_valid_i && !in_stall_o;

  // running sum, restarted by a first byte and closed by a last byte
  always_comb begin
    sum_new = (first_byte_i ? 7'd0 : sum_q) + payload_byte_i[6:0];
    sum_d   = sum_q;
    item_d  = item_q;
    if (accept) begin
      sum_d               = last_byte_i ? 7'd0 : sum_new;
      item_d.req_type     = req_type_i;
      item_d.payload_byte = payload_byte_i;
      item_d.first_byte   = first_byte_i;
      item_d.last_byte    = last_byte_i;
      item_d.cksum        = 7'd0 - sum_new;
    end
  end

  // item valid flag
  always_comb begin
    item_valid_d = item_valid_q;
    if (accept) begin
      item_valid_d = 1'b1;
    end else if (pop_i) begin
      item_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      sum_q        <= 7'd0;
    end else begin
      item_valid_q <= item_valid_d;
      sum_q        <= sum_d;
    end
  end

  // payload register
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign item_valid_o = item_valid_q;
  assign item_o       = item_q;

endmodule

`default_nettype wire

/* rtl/smf_emit.sv */
// ----------------------------------------------------------------------------
// smf_emit
// walks the byte slots of the held item into the output register
// ----------------------------------------------------------------------------
`default_nettype none

module smf_emit (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          item_valid_i,
  input  wire smf_pkg::item_t item_i,
  input  wire logic [6:0]    device_id_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output logic [7:0]         out_byte_o,
  output logic               run_end_o,
  output logic               message_end_o
);
  import smf_pkg::*;

  logic       busy_q, busy_d;
  logic [2:0] slot_q, slot_d;
  logic [2:0] cur_slot;
  logic [2:0] end_slot;
  logic       is_end;
  logic       out_free;
  logic       out_load;
  logic [7:0] byte_sel;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       run_end_q, run_end_d;
  logic       msg_end_q, msg_end_d;

  // slot of the byte to send next
  always_comb begin
    if (busy_q) begin
      cur_slot = slot_q;
    end else begin
      cur_slot = item_i.first_byte ? SLOT_START : SLOT_PAY;
    end
    end_slot = item_i.last_byte ? SLOT_END : SLOT_PAY;
    is_end   = (cur_slot == end_slot);
  end

  assign out_free = !out_valid_q || !out_stall_i;
  assign out_load = item_valid_i && out_free;
  assign pop_o    = out_load && is_end;

  // byte for the current slot
  always_comb begin
    unique case (cur_slot)
      SLOT_START: byte_sel = SYX_START;
      SLOT_MAKER: byte_sel = SYX_MAKER;
      SLOT_DEV:   byte_sel = {1'b0, device_id_i};
      SLOT_MODEL: byte_sel = SYX_MODEL;
      SLOT_CMD:   byte_sel = item_i.req_type ? SYX_CMD_DT : SYX_CMD_RQ;
      SLOT_PAY:   byte_sel = item_i.payload_byte;
      SLOT_CKSUM: byte_sel = {1'b0, item_i.cksum};
      SLOT_END:   byte_sel = SYX_END;
      default:    byte_sel = SYX_END;
    endcase
  end

  // slot sequencer
  always_comb begin
    busy_d = busy_q;
    slot_d = slot_q;
    if (out_load) begin
      busy_d = !is_end;
      slot_d = cur_slot + 3'd1;
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    run_end_d   = run_end_q;
    msg_end_d   = msg_end_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_byte_d  = byte_sel;
      run_end_d   = is_end;
      msg_end_d   = (cur_slot == SLOT_END);
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      slot_q      <= SLOT_START;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      slot_q      <= slot_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    run_end_q  <= run_end_d;
    msg_end_q  <= msg_end_d;
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign run_end_o     = run_end_q;
  assign message_end_o = msg_end_q;

endmodule

`default_nettype wire

/* rtl/smf_checker.sv */
// ----------------------------------------------------------------------------
// smf_checker
// port-level assertions for the sysex message framer
// ----------------------------------------------------------------------------
`default_nettype none

`include "sysex_message_framer_defines.svh"

module smf_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [7:0] out_byte_o,
  input wire logic       run_end_o,
  input wire logic       message_end_o
);

  // stalled output transaction holds
  `SMF_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o), "stalled output changed")

  // closing byte is F7 and ends its run
  `SMF_ASSERT(a_msg_end, clk_i, rst_ni, out_valid_o && message_end_o |-> run_end_o && (out_byte_o == 8'hF7), "bad message end")

  // bytes of one run follow back to back
  `SMF_ASSERT(a_run_cont, clk_i, rst_ni, out_valid_o && !out_stall_i && !run_end_o |=> out_valid_o, "gap inside a run")

  // an edge in reset leaves the output idle
  `SMF_ASSERT_ALWAYS(a_rst_idle, clk_i, !rst_ni |=> !out_valid_o, "output valid after reset edge")

endmodule

bind sysex_message_framer smf_checker u_smf_checker (.*);

`default_nettype wire

/* tb/sv/sysex_frame_checker.sv */
// ----------------------------------------------------------------------------
// sysex frame checker
// watches both channels of the framer, builds the framed bytes that each
// accepted body byte should produce and compares every output transaction
// ----------------------------------------------------------------------------
`default_nettype none

module sysex_frame_checker (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [6:0] cfg_wdata_i,
  input  wire logic       in_valid_i,
  input  wire logic       in_stall_i,
  input  wire logic       req_type_i,
  input  wire logic [7:0] payload_byte_i,
  input  wire logic       first_byte_i,
  input  wire logic       last_byte_i,
  input  wire logic       out_valid_i,
  input  wire logic       out_stall_i,
  input  wire logic [7:0] out_byte_i,
  input  wire logic       run_end_i,
  input  wire logic       message_end_i,
  output int              fail_count_o,
  output int              pending_o,
  output int              bytes_seen_o,
  output int              messages_seen_o
);
  import smf_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       run_end;
    logic       message_end;
  } framed_byte_t;

  framed_byte_t framed_queue[$];
  framed_byte_t want;
  logic [6:0]   device_id;
  logic [6:0]   body_sum;
  int           fail_count    = 0;
  int           bytes_seen    = 0;
  int           messages_seen = 0;

  assign fail_count_o    = fail_count;
  assign bytes_seen_o    = bytes_seen;
  assign messages_seen_o = messages_seen;

  task automatic report(input string msg);
    $display("checker: %s", msg);
    fail_count++;
  endtask

  task automatic push_byte(input logic [7:0] data, input logic run_end,
                           input logic message_end);
    framed_byte_t fb;
    fb.data        = data;
    fb.run_end     = run_end;
    fb.message_end = message_end;
    framed_queue.push_back(fb);
  endtask

  // bytes caused by one body byte: optional header, the byte, optional trailer
  task automatic frame_body_byte(input logic req, input logic [7:0] body,
                                 input logic first, input logic last);
    logic [6:0] check;
    if (first) begin
      body_sum = '0;
      push_byte(SYX_START, 1'b0, 1'b0);
      push_byte(SYX_MAKER, 1'b0, 1'b0);
      push_byte({1'b0, device_id}, 1'b0, 1'b0);
      push_byte(SYX_MODEL, 1'b0, 1'b0);
      push_byte(req ? SYX_CMD_DT : SYX_CMD_RQ, 1'b0, 1'b0);
    end
    push_byte(body, !last, 1'b0);
    // only the low seven bits count toward the checksum
    body_sum = body_sum + body[6:0];
    if (last) begin
      check = 7'd0 - body_sum;
      push_byte({1'b0, check}, 1'b0, 1'b0);
      push_byte(SYX_END, 1'b1, 1'b1);
      body_sum = '0;
    end
  endtask

  // predict on input transactions, compare on output transactions
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      framed_queue.delete();
      device_id = DEVICE_RESET;
      body_sum  = '0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        device_id = cfg_wdata_i;
      end
      if (in_valid_i && !in_stall_i) begin
        frame_body_byte(req_type_i, payload_byte_i, first_byte_i, last_byte_i);
      end
      if (out_valid_i && !out_stall_i) begin
        if (framed_queue.size() == 0) begin
          report($sformatf("byte %0d: unexpected output %02h", bytes_seen, out_byte_i));
        end else begin
          want = framed_queue.pop_front();
          if (out_byte_i !== want.data) begin
            report($sformatf("byte %0d: out_byte %02h, expected %02h",
                             bytes_seen, out_byte_i, want.data));
          end
          if (run_end_i !== want.run_end) begin
            report($sformatf("byte %0d: run_end %b, expected %b",
                             bytes_seen, run_end_i, want.run_end));
          end
          if (message_end_i !== want.message_end) begin
            report($sformatf("byte %0d: message_end %b, expected %b",
                             bytes_seen, message_end_i, want.message_end));
          end
          if (want.message_end) begin
            messages_seen++;
          end
        end
        bytes_seen++;
      end
      pending_o <= framed_queue.size();
    end
  end

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// sysex message framer testbench
// drives body bytes and device id settings into the framer with random gaps
// and output stalls; the checker beside the block predicts and compares
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import smf_pkg::*;

  localparam int   WATCHDOG_LIMIT      = 1000;
  localparam int   HOLD_CYCLES         = 80;
  localparam int   ITEMS_PER_PHASE     = 36;
  localparam logic KIND_REQUEST        = 1'b0;
  localparam logic KIND_UPDATE         = 1'b1;

  typedef struct packed {
    logic       req;
    logic [7:0] data;
    logic       first;
    logic       last;
  } body_item_t;

  logic       clk_i          = 1'b0;
  logic       rst_ni         = 1'b0;
  logic       cfg_we_i       = 1'b0;
  logic [6:0] cfg_wdata_i    = '0;
  logic       in_valid_i     = 1'b0;
  logic       req_type_i     = 1'b0;
  logic [7:0] payload_byte_i = '0;
  logic       first_byte_i   = 1'b0;
  logic       last_byte_i    = 1'b0;
  logic       out_stall_i    = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [7:0] out_byte_o;
  logic       run_end_o;
  logic       message_end_o;

  int fail_count;
  int pending;
  int bytes_seen;
  int messages_seen;
  int items_sent   = 0;
  int idle_cycles  = 0;
  bit quiet        = 1'b0;
  bit squeeze      = 1'b0;
  bit squeezed     = 1'b0;

  sysex_message_framer DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .payload_byte_i (payload_byte_i),
    .first_byte_i   (first_byte_i),
    .last_byte_i    (last_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_byte_o     (out_byte_o),
    .run_end_o      (run_end_o),
    .message_end_o  (message_end_o)
  );

  sysex_frame_checker frame_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .req_type_i      (req_type_i),
    .payload_byte_i  (payload_byte_i),
    .first_byte_i    (first_byte_i),
    .last_byte_i     (last_byte_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_byte_i      (out_byte_o),
    .run_end_i       (run_end_o),
    .message_end_i   (message_end_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .bytes_seen_o    (bytes_seen),
    .messages_seen_o (messages_seen)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (rst_ni && !(in_valid_i && !in_stall_o) && !(out_valid_o && !out_stall_i)) begin
      idle_cycles <= idle_cycles + 1;
    end else begin
      idle_cycles <= 0;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench: no transaction for %0d cycles", idle_cycles);
      $display("testbench: errors");
      $finish;
    end
  end

  // output side: random stalls, one long hold to back the block up
  initial begin
    int gap;
    forever begin
      if (squeeze && !squeezed) begin
        squeezed = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      gap = quiet ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // one input transaction after a random gap
  task automatic send_item(input body_item_t it);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    req_type_i     <= it.req;
    payload_byte_i <= it.data;
    first_byte_i   <= it.first;
    last_byte_i    <= it.last;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  // a message body of len bytes; close leaves off the last mark when clear
  task automatic send_message(input int len, input bit close);
    body_item_t it;
    logic       req;
    req = 1'($urandom_range(0, 1));
    for (int i = 0; i < len; i++) begin
      // req_type only matters on the first byte, so the rest is random
      it.req   = (i == 0) ? req : 1'($urandom_range(0, 1));
      it.data  = 8'($urandom_range(0, 255));
      it.first = (i == 0);
      it.last  = close && (i == len - 1);
      send_item(it);
    end
  endtask

  // wait until every framed byte has come out
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_device(input logic [6:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // mostly well-formed messages, some stray bytes and unfinished messages
  task automatic random_phase();
    int         sent;
    int         len;
    body_item_t it;
    sent = 0;
    while (sent < ITEMS_PER_PHASE) begin
      quiet = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 9))
        0: begin
          len = $urandom_range(1, 3);
          for (int i = 0; i < len; i++) begin
            it = body_item_t'(11'($urandom_range(0, 2047)));
            send_item(it);
          end
        end
        1: begin
          len = $urandom_range(1, 4);
          send_message(len, 1'b0);
        end
        2: begin
          len = $urandom_range(7, 12);
          send_message(len, 1'b1);
        end
        default: begin
          len = $urandom_range(1, 6);
          send_message(len, 1'b1);
        end
      endcase
      sent += len;
    end
    quiet = 1'b0;
  endtask

  initial begin
    logic [6:0] device;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, device id at its reset value
    send_item('{KIND_REQUEST, 8'h12, 1'b0, 1'b0});  // body byte with no open message
    send_item('{KIND_UPDATE,  8'h34, 1'b0, 1'b1});  // closes it with a checksum
    send_item('{KIND_REQUEST, 8'h00, 1'b1, 1'b1});  // one-byte request
    send_item('{KIND_UPDATE,  8'hFF, 1'b1, 1'b1});  // one-byte update, high bit set
    send_item('{KIND_UPDATE,  8'h7F, 1'b1, 1'b0});
    send_item('{KIND_REQUEST, 8'h80, 1'b0, 1'b0});
    send_item('{KIND_UPDATE,  8'h55, 1'b0, 1'b0});
    send_item('{KIND_REQUEST, 8'hAA, 1'b0, 1'b1});
    send_item('{KIND_UPDATE,  8'hC3, 1'b0, 1'b0});  // stray byte after a message end
    send_item('{KIND_REQUEST, 8'h10, 1'b1, 1'b0});  // start drops the stray sum
    send_item('{KIND_UPDATE,  8'h20, 1'b0, 1'b0});
    send_item('{KIND_UPDATE,  8'h01, 1'b1, 1'b1});  // abandons the open message
    send_item('{KIND_REQUEST, 8'h80, 1'b1, 1'b0});  // sum wraps to zero
    send_item('{KIND_REQUEST, 8'h80, 1'b0, 1'b1});
    drain();

    // random phases over several device ids, extremes first
    for (int p = 0; p < 4; p++) begin
      case (p)
        0:       device = 7'd0;
        1:       device = 7'd127;
        default: device = 7'($urandom_range(0, 127));
      endcase
      write_device(device);
      if (p == 1) begin
        squeeze = 1'b1;
      end
      random_phase();
      drain();
    end

    $display("summary: %0d body bytes over five device ids (reset, 0, 127, two random)",
             items_sent);
    $display("summary: %0d framed bytes checked, %0d messages closed", bytes_seen,
             messages_seen);
    if (fail_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
